[rtl/pinhole_projection_with_lens_distortion_assert.svh]
// Assertion macros used by the projection RTL.
`ifndef PINHOLE_PROJECTION_WITH_LENS_DISTORTION_ASSERT_SVH
`define PINHOLE_PROJECTION_WITH_LENS_DISTORTION_ASSERT_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define PPLD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("ppld assertion failed");

// Check that a condition implies a consequence in the same cycle.
`define PPLD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ppld implication failed");

`else

`define PPLD_ASSERT(lbl, clk, rstn, prop)
`define PPLD_ASSERT_IMP(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/ppld_pkg.sv]
// Types, constants and fixed-point helpers of the lens projection pipeline.
package ppld_pkg;

  localparam int STORE_DEPTH = 23;
  localparam int N_EXT       = 12;
  localparam int NORM_FRAC   = 28;
  localparam int DIV_STEPS   = 3 + NORM_FRAC;

  // Coefficient slots.
  localparam int IDX_FX   = 12;
  localparam int IDX_SKEW = 13;
  localparam int IDX_CX   = 14;
  localparam int IDX_K10  = 15;
  localparam int IDX_FY   = 16;
  localparam int IDX_CY   = 17;
  localparam int IDX_K1   = 18;
  localparam int IDX_K2   = 19;
  localparam int IDX_P1   = 20;
  localparam int IDX_P2   = 21;
  localparam int IDX_K3   = 22;

  typedef logic signed [47:0] s48_t;

  localparam s48_t LIM48    = 48'sh7FFF_FFFF_FFFF;
  localparam s48_t ONE_NORM = 48'sh0000_1000_0000;
  localparam logic signed [48:0] LIM49   = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [49:0] PIX_MAX = 50'sh0_0000_7FFF_FFFF;
  localparam logic signed [49:0] PIX_MIN = -50'sh0_0000_8000_0000;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_PROJECT = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [4:0]         coeff_index;
    logic signed [31:0] coeff_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pixel_u;
    logic signed [31:0] pixel_v;
    logic               in_front;
  } out_word_t;

  // Control that travels with every word down the pipeline.
  typedef struct packed {
    logic               vld;
    opcode_e            op;
    logic               front;
    logic [4:0]         idx;
    logic signed [31:0] val;
  } ctl_t;

  // Four 24x24 partial products of a 48x48 magnitude multiply.
  typedef struct packed {
    logic [47:0] ll;
    logic [47:0] lh;
    logic [47:0] hl;
    logic [47:0] hh;
    logic        neg;
  } mpart_t;

  function automatic s48_t sx32(logic signed [31:0] a);
    return {{16{a[31]}}, a};
  endfunction

  function automatic s48_t dbl32(logic signed [31:0] a);
    return {{15{a[31]}}, a, 1'b0};
  endfunction

  function automatic logic [47:0] mag48(s48_t a);
    return a[47] ? 48'(-a) : 48'(a);
  endfunction

  function automatic s48_t add_sat(s48_t a, s48_t b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s > LIM49) begin
      return LIM48;
    end else if (s < -LIM49) begin
      return -LIM48;
    end else begin
      return s[47:0];
    end
  endfunction

  function automatic mpart_t mul_part(s48_t a, s48_t b);
    logic [47:0] ma;
    logic [47:0] mb;
    mpart_t      p;
    ma    = mag48(a);
    mb    = mag48(b);
    p.ll  = 48'(ma[23:0]) * 48'(mb[23:0]);
    p.lh  = 48'(ma[23:0]) * 48'(mb[47:24]);
    p.hl  = 48'(ma[47:24]) * 48'(mb[23:0]);
    p.hh  = 48'(ma[47:24]) * 48'(mb[47:24]);
    p.neg = a[47] ^ b[47];
    return p;
  endfunction

  // Sum partials, truncate toward zero by sh bits, saturate the magnitude.
  // A product past 64 bits saturates regardless of the shift.
  function automatic s48_t mul_fin(mpart_t p, logic [4:0] sh);
    logic [95:0] sum;
    logic [95:0] shd;
    logic [47:0] m;
    sum = {48'd0, p.ll} + {24'd0, p.lh, 24'd0} + {24'd0, p.hl, 24'd0} + {p.hh, 48'd0};
    shd = sum >> sh;
    if ((|sum[95:64]) || (shd > {48'd0, LIM48})) begin
      m = LIM48;
    end else begin
      m = shd[47:0];
    end
    return p.neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat_pix(s48_t a, s48_t b, logic signed [31:0] c);
    logic signed [49:0] s;
    s = {{2{a[47]}}, a} + {{2{b[47]}}, b} + {{18{c[31]}}, c};
    if (s > PIX_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (s < PIX_MIN) begin
      return 32'sh8000_0000;
    end else begin
      return s[31:0];
    end
  endfunction

endpackage

[rtl/pinhole_projection_with_lens_distortion.sv]
// Pinhole projection with radial and tangential lens distortion, fully pipelined.
//
// One word enters per cycle unless the output stalls; a projected pixel is
// presented once its word has passed 51 register stages. The depth is set by
// the 31-step restoring divider (one quotient bit per stage, x and y in parallel)
// and by the 48-bit products, each split into four 24x24 partials over two
// stages. A write word carries one coefficient down the same pipe and commits
// at the stage that reads that coefficient, so every project word sees exactly
// the coefficients written before it, with no drain needed. Write words leave
// no result. The coefficient store resets to zero and needs no clearing pass.
// Out of reset the block takes words at once. A stall on the output freezes the
// whole pipe; the output register keeps the finished pixel while the input side
// stalls only when that register is held.
`include "pinhole_projection_with_lens_distortion_assert.svh"

module pinhole_projection_with_lens_distortion #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  ppld_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output ppld_pkg::out_word_t  out_data_o
);

  // Camera coordinates stay below 2^(65-FRAC_BITS) in magnitude.
  localparam int CW      = 66 - FRAC_BITS;
  localparam int NST     = 51;
  localparam int LAST    = NST - 1;
  localparam int SW      = $clog2(NST);
  localparam int ST_DIV0 = 2;
  localparam int ST_E    = ST_DIV0 + ppld_pkg::DIV_STEPS + 1;
  localparam int ST_K1   = ST_E + 3;
  localparam int ST_P    = ST_E + 4;
  localparam int ST_K2   = ST_E + 5;
  localparam int ST_K3   = ST_E + 7;
  localparam int ST_KM   = ST_E + 13;
  localparam int ST_KC   = ST_E + 15;
  localparam int NXC     = 11;
  localparam int NDC     = 6;
  localparam logic [4:0] SH_F = 5'(FRAC_BITS);
  localparam logic [4:0] SH_N = 5'(ppld_pkg::NORM_FRAC);

  typedef struct packed {
    logic [CW-1:0]                    r;
    logic [2:0]                       lo;
    logic [ppld_pkg::DIV_STEPS-1:0]   q;
    logic                             sat;
    logic                             neg;
  } dstep_t;

  function automatic logic signed [CW-1:0] cam_mul(logic signed [31:0] a,
                                                   logic signed [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] pr;
    logic [63:0] sh;
    ma = a[31] ? 32'(-a) : 32'(a);
    mb = b[31] ? 32'(-b) : 32'(b);
    pr = 64'(ma) * 64'(mb);
    sh = pr >> FRAC_BITS;
    return (a[31] ^ b[31]) ? -CW'(sh) : CW'(sh);
  endfunction

  function automatic dstep_t div_step(dstep_t s, logic [CW-1:0] d);
    logic [CW:0] r2;
    dstep_t      o;
    o    = s;
    r2   = {s.r, s.lo[2]};
    o.lo = {s.lo[1:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      o.r = CW'(r2 - {1'b0, d});
      o.q = {s.q[ppld_pkg::DIV_STEPS-2:0], 1'b1};
    end else begin
      o.r = r2[CW-1:0];
      o.q = {s.q[ppld_pkg::DIV_STEPS-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dstep_t div_init(logic signed [CW-1:0] n, logic [CW-1:0] d);
    logic [CW-1:0] an;
    dstep_t        o;
    an    = n[CW-1] ? CW'(-n) : CW'(n);
    o.r   = an >> 3;
    o.lo  = an[2:0];
    o.q   = '0;
    o.sat = {3'b000, an} >= {d, 3'b000};
    o.neg = n[CW-1];
    return o;
  endfunction

  function automatic ppld_pkg::s48_t to_norm(dstep_t s);
    logic [ppld_pkg::DIV_STEPS-1:0] qv;
    qv = s.sat ? '1 : s.q;
    return s.neg ? -$signed(48'(qv)) : $signed(48'(qv));
  endfunction

  // Stage whose word reads a coefficient; writes to that slot commit there.
  function automatic logic [SW-1:0] use_stage(int j);
    case (j)
      ppld_pkg::IDX_K1:   return SW'(ST_K1);
      ppld_pkg::IDX_K2:   return SW'(ST_K2);
      ppld_pkg::IDX_P1,
      ppld_pkg::IDX_P2:   return SW'(ST_P);
      ppld_pkg::IDX_K3:   return SW'(ST_K3);
      ppld_pkg::IDX_CX,
      ppld_pkg::IDX_CY:   return SW'(ST_KC);
      default:            return SW'(ST_KM);
    endcase
  endfunction

  logic                  en;
  ppld_pkg::ctl_t        ctl_q [NST];
  ppld_pkg::ctl_t        div_ctl_d;
  logic                  front_d;
  logic signed [31:0]    coef_q [ppld_pkg::STORE_DEPTH];
  logic                  wr_en  [ppld_pkg::STORE_DEPTH];
  logic signed [31:0]    wr_val [ppld_pkg::STORE_DEPTH];
  logic signed [31:0]    pt [3];
  logic signed [CW-1:0]  prod_d [9];
  logic signed [CW-1:0]  prod_q [9];
  logic signed [31:0]    trans_q [3];
  logic signed [CW-1:0]  cam_q [3];
  dstep_t                dvx_q [ppld_pkg::DIV_STEPS+1];
  dstep_t                dvy_q [ppld_pkg::DIV_STEPS+1];
  logic [CW-1:0]         ud_q  [ppld_pkg::DIV_STEPS+1];

  ppld_pkg::s48_t  xk_q [NXC];
  ppld_pkg::s48_t  yk_q [NXC];
  ppld_pkg::s48_t  dxk_q [NDC];
  ppld_pkg::s48_t  dyk_q [NDC];
  ppld_pkg::mpart_t pa_xx_q, pa_yy_q, pa_xy_q;
  ppld_pkg::s48_t  xx_q, yy_q, xy36_q;
  ppld_pkg::s48_t  r2_37_q, xx2_q, yy2_q, xy37_q;
  ppld_pkg::mpart_t pa_r4_q, pa_k1_q;
  ppld_pkg::s48_t  sx_q, sy_q, xy38_q, r2_38_q;
  ppld_pkg::s48_t  r4_q, k1r2_q, r2_39_q;
  ppld_pkg::mpart_t pa_pxy_q, pa_qxy_q, pa_dxb_q, pa_dya_q;
  ppld_pkg::mpart_t pa_r6_q, pa_k2_q;
  ppld_pkg::s48_t  pxy_q, qxy_q, dxb_q, dya_q, v1_40_q;
  ppld_pkg::s48_t  r6_q, k2r4_q, v1_41_q;
  ppld_pkg::mpart_t pa_k3_q;
  ppld_pkg::s48_t  v2_42_q, k3r6_q, v2_43_q, v_q;
  ppld_pkg::mpart_t pa_vx_q, pa_vy_q;
  ppld_pkg::s48_t  vx_q, vy_q, xd_q, yd_q;
  ppld_pkg::mpart_t pa_ua_q, pa_ub_q, pa_wa_q, pa_wb_q;
  ppld_pkg::s48_t  ua_q, ub_q, wa_q, wb_q;
  ppld_pkg::out_word_t out_q;

  // Freeze the whole pipe only while a finished pixel is held at the output.
  assign out_valid_o = ctl_q[LAST].vld && (ctl_q[LAST].op == ppld_pkg::OP_PROJECT);
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign out_data_o  = out_q;

  // Depth must be strictly positive for a point to count as in front.
  assign front_d = !cam_q[2][CW-1] && (cam_q[2] != '0);

  // Tag the word entering the divider with its depth test.
  always_comb begin
    div_ctl_d       = ctl_q[ST_DIV0-1];
    div_ctl_d.front = front_d;
  end

  // Route each coefficient write to the stage that consumes the slot.
  always_comb begin
    for (int j = 0; j < ppld_pkg::STORE_DEPTH; j++) begin
      if (j < ppld_pkg::N_EXT) begin
        wr_en[j]  = en && in_valid_i && (in_data_i.opcode == ppld_pkg::OP_WRITE) &&
                    (in_data_i.coeff_index == 5'(j));
        wr_val[j] = in_data_i.coeff_value;
      end else begin
        wr_en[j]  = en && ctl_q[use_stage(j)].vld &&
                    (ctl_q[use_stage(j)].op == ppld_pkg::OP_WRITE) &&
                    (ctl_q[use_stage(j)].idx == 5'(j));
        wr_val[j] = ctl_q[use_stage(j)].val;
      end
    end
  end

  // Rotate the point into camera space, one product per coefficient.
  always_comb begin
    pt[0] = in_data_i.point_x;
    pt[1] = in_data_i.point_y;
    pt[2] = in_data_i.point_z;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[3*i+j] = cam_mul(coef_q[4*i+j], pt[j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < ppld_pkg::STORE_DEPTH; j++) begin
        coef_q[j] <= '0;
      end
    end else begin
      for (int j = 0; j < ppld_pkg::STORE_DEPTH; j++) begin
        if (wr_en[j]) begin
          coef_q[j] <= wr_val[j];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0].vld   <= in_valid_i;
      ctl_q[0].op    <= in_data_i.opcode;
      ctl_q[0].front <= 1'b0;
      ctl_q[0].idx   <= in_data_i.coeff_index;
      ctl_q[0].val   <= in_data_i.coeff_value;
      for (int i = 1; i < NST; i++) begin
        ctl_q[i] <= (i == ST_DIV0) ? div_ctl_d : ctl_q[i-1];
      end
    end
  end

  // Datapath: advance every stage together, payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (en) begin
      // Camera space: products, then sums with the translation.
      for (int i = 0; i < 9; i++) begin
        prod_q[i] <= prod_d[i];
      end
      for (int i = 0; i < 3; i++) begin
        trans_q[i] <= coef_q[4*i+3];
        cam_q[i]   <= prod_q[3*i] + prod_q[3*i+1] + prod_q[3*i+2] +
                      {{(CW-32){trans_q[i][31]}}, trans_q[i]};
      end

      // Normalize: restoring division, one quotient bit per stage.
      dvx_q[0] <= div_init(cam_q[0], cam_q[2]);
      dvy_q[0] <= div_init(cam_q[1], cam_q[2]);
      ud_q[0]  <= cam_q[2];
      for (int k = 0; k < ppld_pkg::DIV_STEPS; k++) begin
        dvx_q[k+1] <= div_step(dvx_q[k], ud_q[k]);
        dvy_q[k+1] <= div_step(dvy_q[k], ud_q[k]);
        ud_q[k+1]  <= ud_q[k];
      end

      // Normalized coordinates, carried until the radial scale is ready.
      xk_q[0] <= to_norm(dvx_q[ppld_pkg::DIV_STEPS]);
      yk_q[0] <= to_norm(dvy_q[ppld_pkg::DIV_STEPS]);
      for (int i = 1; i < NXC; i++) begin
        xk_q[i] <= xk_q[i-1];
        yk_q[i] <= yk_q[i-1];
      end

      // Squares and cross term.
      pa_xx_q <= ppld_pkg::mul_part(xk_q[0], xk_q[0]);
      pa_yy_q <= ppld_pkg::mul_part(yk_q[0], yk_q[0]);
      pa_xy_q <= ppld_pkg::mul_part(xk_q[0], yk_q[0]);
      xx_q    <= ppld_pkg::mul_fin(pa_xx_q, SH_N);
      yy_q    <= ppld_pkg::mul_fin(pa_yy_q, SH_N);
      xy36_q  <= ppld_pkg::mul_fin(pa_xy_q, SH_N);

      r2_37_q <= ppld_pkg::add_sat(xx_q, yy_q);
      xx2_q   <= ppld_pkg::add_sat(xx_q, xx_q);
      yy2_q   <= ppld_pkg::add_sat(yy_q, yy_q);
      xy37_q  <= xy36_q;

      pa_r4_q <= ppld_pkg::mul_part(r2_37_q, r2_37_q);
      pa_k1_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_K1]), r2_37_q);
      sx_q    <= ppld_pkg::add_sat(r2_37_q, xx2_q);
      sy_q    <= ppld_pkg::add_sat(r2_37_q, yy2_q);
      xy38_q  <= xy37_q;
      r2_38_q <= r2_37_q;

      // Tangential products start beside the higher radial powers.
      r4_q     <= ppld_pkg::mul_fin(pa_r4_q, SH_N);
      k1r2_q   <= ppld_pkg::mul_fin(pa_k1_q, SH_F);
      pa_pxy_q <= ppld_pkg::mul_part(ppld_pkg::dbl32(coef_q[ppld_pkg::IDX_P1]), xy38_q);
      pa_qxy_q <= ppld_pkg::mul_part(ppld_pkg::dbl32(coef_q[ppld_pkg::IDX_P2]), xy38_q);
      pa_dxb_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_P2]), sx_q);
      pa_dya_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_P1]), sy_q);
      r2_39_q  <= r2_38_q;

      pa_r6_q <= ppld_pkg::mul_part(r4_q, r2_39_q);
      pa_k2_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_K2]), r4_q);
      pxy_q   <= ppld_pkg::mul_fin(pa_pxy_q, SH_F);
      qxy_q   <= ppld_pkg::mul_fin(pa_qxy_q, SH_F);
      dxb_q   <= ppld_pkg::mul_fin(pa_dxb_q, SH_F);
      dya_q   <= ppld_pkg::mul_fin(pa_dya_q, SH_F);
      v1_40_q <= ppld_pkg::add_sat(ppld_pkg::ONE_NORM, k1r2_q);

      r6_q     <= ppld_pkg::mul_fin(pa_r6_q, SH_N);
      k2r4_q   <= ppld_pkg::mul_fin(pa_k2_q, SH_F);
      dxk_q[0] <= ppld_pkg::add_sat(pxy_q, dxb_q);
      dyk_q[0] <= ppld_pkg::add_sat(dya_q, qxy_q);
      v1_41_q  <= v1_40_q;
      for (int i = 1; i < NDC; i++) begin
        dxk_q[i] <= dxk_q[i-1];
        dyk_q[i] <= dyk_q[i-1];
      end

      // Radial scale accumulates in order k1, k2, k3.
      pa_k3_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_K3]), r6_q);
      v2_42_q <= ppld_pkg::add_sat(v1_41_q, k2r4_q);
      k3r6_q  <= ppld_pkg::mul_fin(pa_k3_q, SH_F);
      v2_43_q <= v2_42_q;
      v_q     <= ppld_pkg::add_sat(v2_43_q, k3r6_q);

      // Distorted coordinates.
      pa_vx_q <= ppld_pkg::mul_part(v_q, xk_q[NXC-1]);
      pa_vy_q <= ppld_pkg::mul_part(v_q, yk_q[NXC-1]);
      vx_q    <= ppld_pkg::mul_fin(pa_vx_q, SH_N);
      vy_q    <= ppld_pkg::mul_fin(pa_vy_q, SH_N);
      xd_q    <= ppld_pkg::add_sat(vx_q, dxk_q[NDC-1]);
      yd_q    <= ppld_pkg::add_sat(vy_q, dyk_q[NDC-1]);

      // Intrinsics.
      pa_ua_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_FX]), xd_q);
      pa_ub_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_SKEW]), yd_q);
      pa_wa_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_K10]), xd_q);
      pa_wb_q <= ppld_pkg::mul_part(ppld_pkg::sx32(coef_q[ppld_pkg::IDX_FY]), yd_q);
      ua_q    <= ppld_pkg::mul_fin(pa_ua_q, SH_N);
      ub_q    <= ppld_pkg::mul_fin(pa_ub_q, SH_N);
      wa_q    <= ppld_pkg::mul_fin(pa_wa_q, SH_N);
      wb_q    <= ppld_pkg::mul_fin(pa_wb_q, SH_N);

      // Drop the pixel to zero for a point behind the camera.
      if (ctl_q[LAST-1].front) begin
        out_q.pixel_u  <= ppld_pkg::sat_pix(ua_q, ub_q, coef_q[ppld_pkg::IDX_CX]);
        out_q.pixel_v  <= ppld_pkg::sat_pix(wa_q, wb_q, coef_q[ppld_pkg::IDX_CY]);
        out_q.in_front <= 1'b1;
      end else begin
        out_q.pixel_u  <= '0;
        out_q.pixel_v  <= '0;
        out_q.in_front <= 1'b0;
      end
    end
  end

  `PPLD_ASSERT_IMP(a_behind_zero, clk_i, rst_ni, out_valid_o && !out_data_o.in_front, (out_data_o.pixel_u == '0) && (out_data_o.pixel_v == '0))
  `PPLD_ASSERT_IMP(a_div_rem_x, clk_i, rst_ni, ctl_q[ST_E-1].vld && ctl_q[ST_E-1].front && !dvx_q[ppld_pkg::DIV_STEPS].sat, dvx_q[ppld_pkg::DIV_STEPS].r < ud_q[ppld_pkg::DIV_STEPS])
  `PPLD_ASSERT_IMP(a_div_rem_y, clk_i, rst_ni, ctl_q[ST_E-1].vld && ctl_q[ST_E-1].front && !dvy_q[ppld_pkg::DIV_STEPS].sat, dvy_q[ppld_pkg::DIV_STEPS].r < ud_q[ppld_pkg::DIV_STEPS])
  `PPLD_ASSERT(a_freeze_holds_pipe, clk_i, rst_ni, !en |=> (ctl_q[ST_E] == $past(ctl_q[ST_E])))

endmodule

[tb/tb_pinhole_projection_checker.sv]
// Checker for the lens projection block: predicts pixels and compares them.
`timescale 1ns / 100ps

module tb_pinhole_projection_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ppld_pkg::in_word_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ppld_pkg::out_word_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam longint LIM_48  = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint LIM_CAM = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic signed [31:0]  coeff_mem [ppld_pkg::STORE_DEPTH];
  ppld_pkg::out_word_t pixel_q [$];

  // Truncate a*b >> s toward zero, saturate the magnitude to lim.
  function automatic longint fx_mul(longint a, longint b, int s, longint lim);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  p;
    logic [127:0] full;
    ua   = (a < 0) ? 64'(-a) : 64'(a);
    ub   = (b < 0) ? 64'(-b) : 64'(b);
    full = 128'(ua) * 128'(ub);
    if (full[127:64] != 0) begin
      p = 64'(lim);
    end else begin
      p = full[63:0] >> s;
    end
    if (p > 64'(lim)) p = 64'(lim);
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint sat_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > LIM_48) return LIM_48;
    if (s < -LIM_48) return -LIM_48;
    return s;
  endfunction

  // Quotient in Q4.28, den positive, saturated when |num| >= 8*den.
  function automatic longint norm_div(longint num, longint den);
    logic [63:0] an;
    logic [63:0] ud;
    logic [63:0] q;
    logic [63:0] r;
    an = (num < 0) ? 64'(-num) : 64'(num);
    ud = 64'(den);
    if (an >= (ud << 3)) begin
      q = 64'h7FFF_FFFF;
    end else begin
      q = an / ud;
      r = an % ud;
      for (int i = 0; i < ppld_pkg::NORM_FRAC; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q[0] = 1'b1;
        end
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint cf(int i);
    return longint'(coeff_mem[i]);
  endfunction

  function automatic logic signed [31:0] clamp_pix(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic ppld_pkg::out_word_t project_point(ppld_pkg::in_word_t w);
    longint              pt [3];
    longint              cam [3];
    longint              x, y, xx, yy, xy, r2, r4, r6, gain, dx, dy, xd, yd;
    ppld_pkg::out_word_t res;
    pt[0] = longint'(w.point_x);
    pt[1] = longint'(w.point_y);
    pt[2] = longint'(w.point_z);
    for (int i = 0; i < 3; i++) begin
      cam[i] = fx_mul(cf(4*i), pt[0], FRAC_BITS, LIM_CAM)
             + fx_mul(cf(4*i+1), pt[1], FRAC_BITS, LIM_CAM)
             + fx_mul(cf(4*i+2), pt[2], FRAC_BITS, LIM_CAM) + cf(4*i+3);
    end
    res = '0;
    if (cam[2] <= 0) return res;
    x  = norm_div(cam[0], cam[2]);
    y  = norm_div(cam[1], cam[2]);
    xx = fx_mul(x, x, ppld_pkg::NORM_FRAC, LIM_48);
    yy = fx_mul(y, y, ppld_pkg::NORM_FRAC, LIM_48);
    xy = fx_mul(x, y, ppld_pkg::NORM_FRAC, LIM_48);
    r2 = sat_add(xx, yy);
    r4 = fx_mul(r2, r2, ppld_pkg::NORM_FRAC, LIM_48);
    r6 = fx_mul(r4, r2, ppld_pkg::NORM_FRAC, LIM_48);
    gain = longint'(1) <<< ppld_pkg::NORM_FRAC;
    gain = sat_add(gain, fx_mul(cf(ppld_pkg::IDX_K1), r2, FRAC_BITS, LIM_48));
    gain = sat_add(gain, fx_mul(cf(ppld_pkg::IDX_K2), r4, FRAC_BITS, LIM_48));
    gain = sat_add(gain, fx_mul(cf(ppld_pkg::IDX_K3), r6, FRAC_BITS, LIM_48));
    dx = sat_add(fx_mul(2 * cf(ppld_pkg::IDX_P1), xy, FRAC_BITS, LIM_48),
                 fx_mul(cf(ppld_pkg::IDX_P2), sat_add(r2, sat_add(xx, xx)),
                        FRAC_BITS, LIM_48));
    dy = sat_add(fx_mul(cf(ppld_pkg::IDX_P1), sat_add(r2, sat_add(yy, yy)),
                        FRAC_BITS, LIM_48),
                 fx_mul(2 * cf(ppld_pkg::IDX_P2), xy, FRAC_BITS, LIM_48));
    xd = sat_add(fx_mul(gain, x, ppld_pkg::NORM_FRAC, LIM_48), dx);
    yd = sat_add(fx_mul(gain, y, ppld_pkg::NORM_FRAC, LIM_48), dy);
    res.pixel_u  = clamp_pix(fx_mul(cf(ppld_pkg::IDX_FX), xd, ppld_pkg::NORM_FRAC, LIM_48)
                           + fx_mul(cf(ppld_pkg::IDX_SKEW), yd, ppld_pkg::NORM_FRAC, LIM_48)
                           + cf(ppld_pkg::IDX_CX));
    res.pixel_v  = clamp_pix(fx_mul(cf(ppld_pkg::IDX_K10), xd, ppld_pkg::NORM_FRAC, LIM_48)
                           + fx_mul(cf(ppld_pkg::IDX_FY), yd, ppld_pkg::NORM_FRAC, LIM_48)
                           + cf(ppld_pkg::IDX_CY));
    res.in_front = 1'b1;
    return res;
  endfunction

  assign pending_o = pixel_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    ppld_pkg::out_word_t want;
    if (!rst_ni) begin
      foreach (coeff_mem[i]) coeff_mem[i] = '0;
      pixel_q.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.opcode == ppld_pkg::OP_PROJECT) begin
          pixel_q.push_back(project_point(in_data_i));
        end else if (in_data_i.coeff_index < ppld_pkg::STORE_DEPTH) begin
          coeff_mem[in_data_i.coeff_index] = in_data_i.coeff_value;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel word u=%0d v=%0d", out_data_i.pixel_u, out_data_i.pixel_v);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = pixel_q.pop_front();
          if (out_data_i.pixel_u !== want.pixel_u) begin
            $error("pixel_u expected %0d actual %0d", want.pixel_u, out_data_i.pixel_u);
            fail_count_o <= fail_count_o + 1;
          end else if (out_data_i.pixel_v !== want.pixel_v) begin
            $error("pixel_v expected %0d actual %0d", want.pixel_v, out_data_i.pixel_v);
            fail_count_o <= fail_count_o + 1;
          end else if (out_data_i.in_front !== want.in_front) begin
            $error("in_front expected %0b actual %0b", want.in_front, out_data_i.in_front);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb_pinhole_projection_with_lens_distortion.sv]
// Top of the lens projection testbench: stimulus, backpressure and verdict.
`timescale 1ns / 100ps

module tb_pinhole_projection_with_lens_distortion;

  localparam int     RAND_ITEMS  = 1050;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int     DRAIN_WAIT  = 80;   // pipe is 51 deep

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  ppld_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  ppld_pkg::out_word_t out_data;
  int                  fail_count;
  int                  pending;
  longint              cycles;

  pinhole_projection_with_lens_distortion dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  tb_pinhole_projection_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort on a hung pipe.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Receiver backpressure: mostly short stalls, a few long ones, some calm stretches.
  initial begin
    int run;
    out_stall <= 1'b0;
    @(posedge rst_n);
    forever begin
      case ($urandom_range(0, 9))
        0, 1: begin
          out_stall <= 1'b0;
          run = $urandom_range(20, 120);
        end
        2: begin
          out_stall <= 1'b1;
          run = $urandom_range(15, 60);
        end
        default: begin
          out_stall <= $urandom_range(0, 2) == 0;
          run = $urandom_range(1, 3);
        end
      endcase
      repeat (run) @(posedge clk);
    end
  end

  // Hold the word until a clean edge accepts it; stall settles by the falling edge.
  task automatic push_word(ppld_pkg::in_word_t w);
    bit go;
    in_valid <= 1'b1;
    in_data  <= w;
    do begin
      @(negedge clk);
      go = !in_stall;
      @(posedge clk);
    end while (!go);
  endtask

  // Drop valid for a random gap, mostly short, a few long; none most of the time.
  task automatic sender_gap();
    int n;
    case ($urandom_range(0, 19))
      0:       n = $urandom_range(10, 50);
      1, 2, 3: n = $urandom_range(1, 4);
      default: n = 0;
    endcase
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic ppld_pkg::in_word_t coeff_word(int idx, logic signed [31:0] val);
    ppld_pkg::in_word_t w;
    w = '0;
    w.opcode      = ppld_pkg::OP_WRITE;
    w.coeff_index = 5'(idx);
    w.coeff_value = val;
    w.point_x     = $urandom;
    w.point_y     = $urandom;
    w.point_z     = $urandom;
    return w;
  endfunction

  function automatic ppld_pkg::in_word_t point_word(logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
    ppld_pkg::in_word_t w;
    w.opcode      = ppld_pkg::OP_PROJECT;
    w.coeff_index = 5'($urandom);
    w.coeff_value = $urandom;
    w.point_x     = x;
    w.point_y     = y;
    w.point_z     = z;
    return w;
  endfunction

  function automatic logic signed [31:0] q16(int lo, int hi);
    return 32'(($urandom_range(0, hi - lo) + lo)) <<< 16;
  endfunction

  // Signed value in [-span, span] raw units.
  function automatic logic signed [31:0] around0(int span);
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Load a full camera: plausible rig most of the time, wild values otherwise.
  task automatic load_camera(bit wild);
    logic signed [31:0] c [ppld_pkg::STORE_DEPTH];
    for (int i = 0; i < ppld_pkg::N_EXT; i++) c[i] = around0(65536);
    c[3]  = around0(4 << 16);
    c[7]  = around0(4 << 16);
    c[11] = q16(2, 40);
    c[ppld_pkg::IDX_FX]   = q16(100, 2000);
    c[ppld_pkg::IDX_SKEW] = around0(1 << 14);
    c[ppld_pkg::IDX_CX]   = q16(0, 1000);
    c[ppld_pkg::IDX_K10]  = around0(1 << 12);
    c[ppld_pkg::IDX_FY]   = q16(100, 2000);
    c[ppld_pkg::IDX_CY]   = q16(0, 800);
    c[ppld_pkg::IDX_K1]   = around0(30000);
    c[ppld_pkg::IDX_K2]   = around0(10000);
    c[ppld_pkg::IDX_P1]   = around0(2000);
    c[ppld_pkg::IDX_P2]   = around0(2000);
    c[ppld_pkg::IDX_K3]   = around0(5000);
    if (wild) begin
      for (int i = 0; i < ppld_pkg::STORE_DEPTH; i++) begin
        if ($urandom_range(0, 2) == 0) c[i] = $urandom;
      end
    end
    for (int i = 0; i < ppld_pkg::STORE_DEPTH; i++) begin
      push_word(coeff_word(i, c[i]));
      sender_gap();
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n    <= 1'b1;
    @(posedge clk);

    // Empty store: depth is zero, so the point is behind.
    push_word(point_word(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000));
    // Identity rig, no distortion, unit focal length.
    for (int i = 0; i < ppld_pkg::STORE_DEPTH; i++) push_word(coeff_word(i, '0));
    push_word(coeff_word(0, 32'sh0001_0000));
    push_word(coeff_word(5, 32'sh0001_0000));
    push_word(coeff_word(10, 32'sh0001_0000));
    push_word(coeff_word(ppld_pkg::IDX_FX, 32'sh0001_0000));
    push_word(coeff_word(ppld_pkg::IDX_FY, 32'sh0001_0000));
    push_word(point_word(32'sh0000_8000, -32'sh0000_4000, 32'sh0002_0000));
    push_word(point_word(0, 0, -32'sh0001_0000));            // behind the camera
    push_word(point_word(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001)); // normalized overflow
    push_word(point_word(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    // Slots past the store are ignored.
    push_word(coeff_word(23, 32'sh7FFF_FFFF));
    push_word(coeff_word(31, 32'sh8000_0000));
    // Strong distortion and extreme intrinsics exercise the saturation paths.
    push_word(coeff_word(ppld_pkg::IDX_K1, 32'sh7FFF_FFFF));
    push_word(coeff_word(ppld_pkg::IDX_P1, 32'sh8000_0000));
    push_word(coeff_word(ppld_pkg::IDX_P2, 32'sh7FFF_FFFF));
    push_word(coeff_word(ppld_pkg::IDX_K3, 32'sh8000_0000));
    push_word(coeff_word(ppld_pkg::IDX_CX, 32'sh7FFF_FFFF));
    push_word(point_word(32'sh0003_0000, 32'sh0005_0000, 32'sh0001_0000));
    push_word(point_word(-32'sh0000_0100, 32'sh0000_0100, 32'sh0010_0000));

    // Random part: loaded cameras followed by bursts of points.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 120 == 0) begin
        load_camera($urandom_range(0, 3) == 0);
      end
      if (n == 600) begin
        // Let the pipe drain fully before going on.
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
      case ($urandom_range(0, 19))
        0:       push_word(coeff_word($urandom_range(0, 31), $urandom));
        1, 2:    push_word(point_word($urandom, $urandom, $urandom));
        default: push_word(point_word(around0(10 << 16), around0(10 << 16),
                                      around0(20 << 16)));
      endcase
      sender_gap();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
